>>> design/wbct_pkg.sv
// Shared types and codes of the write-back block cache tag controller.
// No dependencies; imported by wbct_front, wbct_back and the top level.
package wbct_pkg;

    localparam int BLK_W  = 32;
    localparam int SLOT_W = 4;

    typedef enum logic [1:0] {
        CMD_GET   = 2'd0,
        CMD_MARK  = 2'd1,
        CMD_INV   = 2'd2,
        CMD_FLUSH = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_HIT  = 2'd0,
        ACT_FILL = 2'd1,
        ACT_WB   = 2'd2,
        ACT_ACK  = 2'd3
    } t_action;

    typedef struct packed {
        t_cmd             cmd;
        logic [BLK_W-1:0] blk;
    } t_req;

    typedef struct packed {
        t_action           action;
        logic [SLOT_W-1:0] slot;
        logic [BLK_W-1:0]  target;
        logic              found;
        logic              last;
    } t_res;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_queue_head;

endpackage

>>> design/wbct_front.sv
// Front end: accepts request transactions, decodes the command and holds them
// in a two-entry queue for the back end. Depends on wbct_pkg.
module wbct_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [wbct_pkg::BLK_W-1:0]     i_s_tdata,   // [31:0] block_number
    input  logic [1:0]                     i_s_tuser,   // [1:0] cmd
    output wbct_pkg::t_queue_head          o_head,
    input  logic                           i_pop
);
    import wbct_pkg::*;

    t_req       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    t_req       w_in;

    assign o_s_tready   = (r_cnt != 2'd2);
    assign w_push       = i_s_tvalid && o_s_tready;
    assign w_pop        = i_pop && (r_cnt != 2'd0);
    assign w_in.cmd     = t_cmd'(i_s_tuser);
    assign w_in.blk     = i_s_tdata;
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.req   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

>>> design/wbct_back.sv
// Back end: slot state, parallel tag lookup, victim choice and result
// sequencing into the output register. Depends on wbct_pkg.
module wbct_back #(
    parameter int ENTRIES    = 16,
    parameter int BLOCK_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wbct_pkg::t_queue_head i_head,
    output logic                  o_pop,
    output wbct_pkg::t_res        o_res,
    output logic                  o_res_valid,
    input  logic                  i_res_ready
);
    import wbct_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SECOND
    } t_state;

    t_state                r_state, n_state;
    t_req                  r_req;
    logic [ENTRIES-1:0]    r_valid, n_valid;
    logic [ENTRIES-1:0]    r_dirty, n_dirty;
    logic [BLOCK_BITS-1:0] r_tag [ENTRIES];
    t_res                  r_second, n_second;
    t_res                  r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic [BLOCK_BITS-1:0] w_blk_ext;
    logic [BLK_W-1:0]      w_blk_out;
    logic [ENTRIES-1:0]    w_hit_vec;
    logic [ENTRIES-1:0]    w_wb_vec;
    logic                  w_hit_any;
    logic [IDX_W-1:0]      w_hit_idx;
    logic [IDX_W-1:0]      w_vic_idx;
    logic [IDX_W-1:0]      w_wb_idx;
    logic                  w_need_wb;
    logic                  w_out_free;
    logic                  w_tag_we;

    function automatic logic [IDX_W-1:0] first_idx(input logic [ENTRIES-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    assign w_blk_ext = BLOCK_BITS'(r_req.blk);
    assign w_blk_out = BLK_W'(w_blk_ext);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_hit_vec[i] = r_valid[i] && (r_tag[i] == w_blk_ext);
        end
    end

    assign w_wb_vec   = r_valid & r_dirty;
    assign w_hit_any  = |w_hit_vec;
    assign w_hit_idx  = first_idx(w_hit_vec);
    assign w_vic_idx  = (|(~r_valid)) ? first_idx(~r_valid) : first_idx(~r_dirty);
    assign w_need_wb  = !(|(~r_valid)) && !(|(~r_dirty));
    assign w_wb_idx   = first_idx(w_wb_vec);
    assign w_out_free = !r_out_valid || i_res_ready;

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_dirty     = r_dirty;
        n_second    = r_second;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_res_ready;
        o_pop       = 1'b0;
        w_tag_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    unique case (r_req.cmd)
                        CMD_GET: begin
                            if (w_hit_any) begin
                                n_out = '{action: ACT_HIT, slot: SLOT_W'(w_hit_idx),
                                          target: w_blk_out, found: 1'b1, last: 1'b1};
                            end else begin
                                w_tag_we           = 1'b1;
                                n_valid[w_vic_idx] = 1'b1;
                                n_dirty[w_vic_idx] = 1'b0;
                                if (w_need_wb) begin
                                    n_out    = '{action: ACT_WB, slot: '0,
                                                 target: BLK_W'(r_tag[0]),
                                                 found: 1'b0, last: 1'b0};
                                    n_second = '{action: ACT_FILL, slot: '0,
                                                 target: w_blk_out, found: 1'b0, last: 1'b1};
                                    n_state  = S_SECOND;
                                end else begin
                                    n_out = '{action: ACT_FILL, slot: SLOT_W'(w_vic_idx),
                                              target: w_blk_out, found: 1'b0, last: 1'b1};
                                end
                            end
                        end
                        CMD_MARK: begin
                            if (w_hit_any) begin
                                n_dirty[w_hit_idx] = 1'b1;
                            end
                            n_out = '{action: ACT_ACK, slot: SLOT_W'(w_hit_idx),
                                      target: w_blk_out, found: w_hit_any, last: 1'b1};
                        end
                        CMD_INV: begin
                            if (w_hit_any) begin
                                n_valid[w_hit_idx] = 1'b0;
                                n_dirty[w_hit_idx] = 1'b0;
                            end
                            if (w_hit_any && r_dirty[w_hit_idx]) begin
                                n_out    = '{action: ACT_WB, slot: SLOT_W'(w_hit_idx),
                                             target: w_blk_out, found: 1'b1, last: 1'b0};
                                n_second = '{action: ACT_ACK, slot: SLOT_W'(w_hit_idx),
                                             target: w_blk_out, found: 1'b1, last: 1'b1};
                                n_state  = S_SECOND;
                            end else begin
                                n_out = '{action: ACT_ACK, slot: SLOT_W'(w_hit_idx),
                                          target: w_blk_out, found: w_hit_any, last: 1'b1};
                            end
                        end
                        CMD_FLUSH: begin
                            if (|w_wb_vec) begin
                                n_dirty[w_wb_idx] = 1'b0;
                                n_out   = '{action: ACT_WB, slot: SLOT_W'(w_wb_idx),
                                            target: BLK_W'(r_tag[w_wb_idx]),
                                            found: 1'b0, last: 1'b0};
                                n_state = S_LOOK;
                            end else begin
                                n_out = '{action: ACT_ACK, slot: '0, target: '0,
                                          found: 1'b0, last: 1'b1};
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SECOND: begin
                if (w_out_free) begin
                    n_out       = r_second;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_tag_we) begin
            r_tag[w_vic_idx] <= w_blk_ext;
        end
        if (o_pop) begin
            r_req <= i_head.req;
        end
        r_second <= n_second;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_dirty     <= n_dirty;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

endmodule

>>> design/writeback_block_cache_tags_unit.sv
// Top level of the write-back block cache tag controller.
// Instantiates wbct_front (request queue) and wbct_back; depends on wbct_pkg.
// Usage:
//   Slave side takes one request transaction: tuser = cmd (get, mark dirty,
//   invalidate, flush), tdata = block number. Master side returns one or more
//   result transactions per request; tlast marks the final one. tuser carries
//   action and the found flag, tdata carries slot and target block.
//   A get miss with every slot dirty first writes back slot 0, then fills.
//   Invalidate of a dirty match writes it back before the acknowledge.
//   Flush writes back every valid dirty slot in slot order, then acknowledges.
// Sequencing:
//   Requests enter a two-entry queue. The back end takes one request at a
//   time: it pops it in S_IDLE, then in S_LOOK the parallel tag compare
//   produces the first result; a second result, when one follows, comes
//   from S_SECOND. Flush returns to S_LOOK for each dirty slot it writes
//   back. A result is registered only while the output is free.
// Reset and stalls:
//   Reset clears all valid and dirty bits and empties the queue. While the
//   master side stalls, the output register holds and the back end waits;
//   the queue keeps accepting until it holds two requests.
module writeback_block_cache_tags_unit #(
    parameter int ENTRIES    = 16,
    parameter int BLOCK_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] block_number
    input  logic [1:0]  i_s_tuser,   // [1:0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [3:0] slot, [35:4] target_block, [39:36] zero
    output logic [2:0]  o_m_tuser,   // [1:0] action, [2] found
    output logic        o_m_tlast
);
    import wbct_pkg::*;

    t_queue_head w_head;
    logic        w_pop;
    t_res        w_res;

    wbct_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    wbct_back #(
        .ENTRIES    (ENTRIES),
        .BLOCK_BITS (BLOCK_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_res       (w_res),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready)
    );

    assign o_m_tdata = {4'b0, w_res.target, w_res.slot};
    assign o_m_tuser = {w_res.found, w_res.action};
    assign o_m_tlast = w_res.last;

    a_ack_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser[1:0] == ACT_ACK || o_m_tuser[1:0] == ACT_FILL))
            |-> o_m_tlast)
        else $error("acknowledge or fill not marked last");

    a_wb_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1:0] == ACT_WB) |-> !o_m_tlast)
        else $error("write-back marked last");

    a_hit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1:0] == ACT_HIT) |-> (o_m_tuser[2] && o_m_tlast))
        else $error("hit without found flag");

endmodule
